// ----- design/osv_pkg.sv -----
package osv_pkg;

    localparam int DEPTH      = 128;
    localparam int WORD_WIDTH = 64;
    localparam int NUM_VARS   = 26;

    // port widths fixed by the interface
    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 64;
    localparam int VIX_W    = 5;
    localparam int STATUS_W = 2;
    localparam int SDEPTH_W = 8;

    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int PTR_W     = $clog2(DEPTH + 1);
    localparam int VAR_AW    = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int VIX_EXT_W = (VAR_AW > VIX_W) ? VAR_AW : VIX_W;

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [FUNC_W-1:0]     func_t;

    localparam func_t OP_PUSH  = 3'd0;
    localparam func_t OP_POP   = 3'd1;
    localparam func_t OP_TOP   = 3'd2;
    localparam func_t OP_DUP   = 3'd3;
    localparam func_t OP_SWAP  = 3'd4;
    localparam func_t OP_CLEAR = 3'd5;
    localparam func_t OP_STORE = 3'd6;
    localparam func_t OP_READ  = 3'd7;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_FEW   = 2'd3;

endpackage

// ----- design/osv_ram.sv -----
module osv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/operand_stack_with_variables.sv -----
// LIFO operand stack with variable registers. Pulse start while busy is low to issue a request;
// exactly one result follows, shown for a single cycle with done high, and it must be captured
// then since the block cannot be held off. A new request is taken only once busy is low again.
// Push, clear, read variable and any request that fails its check end in the decode state; pop,
// top, dup and store then visit S_RD_A, and swap visits S_RD_A, S_RD_B and S_SWAP_WR. The single
// stack RAM with a registered read port is visited once per cycle; swap reads both words, then
// writes them back in S_RD_B and S_SWAP_WR. Variables read as zero after reset.
module operand_stack_with_variables
    import osv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [VALUE_W-1:0]  push_value,
    input  logic [VIX_W-1:0]    var_index,
    output logic                done,
    output logic [VALUE_W-1:0]  result_value,
    output logic [STATUS_W-1:0] status,
    output logic [SDEPTH_W-1:0] stack_depth
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_RD_A    = 3'd2;
    localparam logic [2:0] S_RD_B    = 3'd3;
    localparam logic [2:0] S_SWAP_WR = 3'd4;

    localparam ptr_t PTR_FULL = PTR_W'(DEPTH);
    localparam ptr_t PTR_ONE  = PTR_W'(1);
    localparam ptr_t PTR_TWO  = PTR_W'(2);

    logic [2:0] state_reg, state_next;
    ptr_t       sp_reg, sp_next;
    logic       done_reg, done_next;

    func_t             op_reg;
    word_t             word_reg;
    logic [VIX_W-1:0]  vix_reg;
    word_t             tmp_reg, tmp_next;
    word_t             res_value_reg, res_value_next;
    status_t           res_status_reg, res_status_next;
    ptr_t              res_depth_reg;

    word_t             var_mem_reg [NUM_VARS];
    logic [NUM_VARS-1:0] var_vld_reg;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    word_t             ram_wdata, ram_rdata;

    logic [VIX_EXT_W-1:0] vix_ext;
    logic [VAR_AW-1:0]    var_idx;
    logic                 var_in_range;
    logic                 var_we;
    word_t                var_rd;

    logic [ADDR_W-1:0] addr_top, addr_below, addr_free;
    logic              emit;

    osv_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign vix_ext      = VIX_EXT_W'(vix_reg);
    assign var_idx      = vix_ext[VAR_AW-1:0];
    assign var_in_range = 32'(vix_reg) < NUM_VARS;
    assign var_rd       = (var_in_range && var_vld_reg[var_idx]) ? var_mem_reg[var_idx] : '0;

    assign addr_top   = ADDR_W'(sp_reg - PTR_ONE);
    assign addr_below = ADDR_W'(sp_reg - PTR_TWO);
    assign addr_free  = ADDR_W'(sp_reg);

    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        tmp_next        = tmp_reg;
        emit            = 1'b0;
        res_value_next  = '0;
        res_status_next = ST_OK;
        ram_we          = 1'b0;
        ram_waddr       = addr_free;
        ram_wdata       = word_reg;
        ram_re          = 1'b0;
        ram_raddr       = addr_top;
        var_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (op_reg) inside
                    OP_PUSH:
                    begin
                        emit = 1'b1;
                        if (sp_reg < PTR_FULL)
                        begin
                            ram_we  = 1'b1;
                            sp_next = sp_reg + PTR_ONE;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                    OP_POP, OP_TOP, OP_STORE:
                    begin
                        if (sp_reg == '0)
                        begin
                            emit            = 1'b1;
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = S_RD_A;
                        end
                    end
                    OP_DUP:
                    begin
                        if (sp_reg == '0)
                        begin
                            emit            = 1'b1;
                            res_status_next = ST_EMPTY;
                        end
                        else if (sp_reg >= PTR_FULL)
                        begin
                            emit            = 1'b1;
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = S_RD_A;
                        end
                    end
                    OP_SWAP:
                    begin
                        if (sp_reg < PTR_TWO)
                        begin
                            emit            = 1'b1;
                            res_status_next = ST_FEW;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = S_RD_A;
                        end
                    end
                    OP_CLEAR:
                    begin
                        emit    = 1'b1;
                        sp_next = '0;
                    end
                    default:
                    begin
                        emit           = 1'b1;
                        res_value_next = var_rd;
                    end
                endcase
            end
            S_RD_A:
            begin
                // top word now on the RAM read port
                case (op_reg)
                    OP_SWAP:
                    begin
                        tmp_next   = ram_rdata;
                        ram_re     = 1'b1;
                        ram_raddr  = addr_below;
                        state_next = S_RD_B;
                    end
                    OP_POP:
                    begin
                        emit           = 1'b1;
                        res_value_next = ram_rdata;
                        sp_next        = sp_reg - PTR_ONE;
                    end
                    OP_DUP:
                    begin
                        emit           = 1'b1;
                        res_value_next = ram_rdata;
                        ram_we         = 1'b1;
                        ram_wdata      = ram_rdata;
                        sp_next        = sp_reg + PTR_ONE;
                    end
                    OP_STORE:
                    begin
                        emit           = 1'b1;
                        res_value_next = ram_rdata;
                        var_we         = var_in_range;
                    end
                    default:
                    begin
                        emit           = 1'b1;
                        res_value_next = ram_rdata;
                    end
                endcase
            end
            S_RD_B:
            begin
                emit           = 1'b1;
                res_value_next = ram_rdata;
                ram_we         = 1'b1;
                ram_waddr      = addr_top;
                ram_wdata      = ram_rdata;
                state_next     = S_SWAP_WR;
            end
            S_SWAP_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = addr_below;
                ram_wdata  = tmp_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit && state_reg != S_RD_B)
        begin
            state_next = S_IDLE;
        end
        done_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            done_reg    <= 1'b0;
            var_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            done_reg  <= done_next;
            if (var_we)
            begin
                var_vld_reg[var_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == S_IDLE)
        begin
            op_reg   <= func;
            word_reg <= push_value[WORD_WIDTH-1:0];
            vix_reg  <= var_index;
        end
        tmp_reg <= tmp_next;
        if (emit)
        begin
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
            res_depth_reg  <= sp_next;
        end
        if (var_we)
        begin
            var_mem_reg[var_idx] <= ram_rdata;
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign result_value = VALUE_W'(res_value_reg);
    assign status       = res_status_reg;
    assign stack_depth  = SDEPTH_W'(res_depth_reg);

    a_done_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in progress");

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= PTR_FULL)
        else $error("stack pointer beyond depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (result_value == '0))
        else $error("failed request returned a non-zero word");

endmodule

// ----- tb/operand_stack_with_variables_tb.sv -----
module operand_stack_with_variables_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import osv_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 120;

    typedef struct packed {
        word_t                 value;
        status_t               status;
        logic [SDEPTH_W-1:0]   depth;
    } stack_result_t;

    typedef struct {
        func_t                 op;
        word_t                 word;
        logic [VIX_W-1:0]      vix;
        bit                    typed;
        stack_result_t         want;
    } directed_row_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [FUNC_W-1:0]   func = OP_PUSH;
    logic [VALUE_W-1:0]  push_value = '0;
    logic [VIX_W-1:0]    var_index = '0;
    logic                done;
    logic [VALUE_W-1:0]  result_value;
    logic [STATUS_W-1:0] status;
    logic [SDEPTH_W-1:0] stack_depth;

    // shadow copy of the stack and the variable bank
    word_t model_stack [DEPTH];
    word_t var_bank [NUM_VARS];
    int    model_depth = 0;

    stack_result_t pending_results [$];
    directed_row_t directed_rows [$];
    int            idle_pct = 0;
    int            errors = 0;
    int            cycles = 0;

    operand_stack_with_variables i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .push_value   (push_value),
        .var_index    (var_index),
        .done         (done),
        .result_value (result_value),
        .status       (status),
        .stack_depth  (stack_depth)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb: mismatch on %s: got %h, want %h", what, got, want);
        errors++;
    endtask

    task automatic compute_stack_op(input func_t op, input word_t word,
                                    input logic [VIX_W-1:0] vix,
                                    output stack_result_t res);
        word_t   v;
        status_t st;
        word_t   t;
        v  = '0;
        st = ST_OK;
        case (op)
            OP_PUSH:
                if (model_depth < DEPTH)
                begin
                    model_stack[model_depth] = word;
                    model_depth++;
                end
                else
                    st = ST_FULL;
            OP_POP:
                if (model_depth > 0)
                begin
                    model_depth--;
                    v = model_stack[model_depth];
                end
                else
                    st = ST_EMPTY;
            OP_TOP:
                if (model_depth > 0)
                    v = model_stack[model_depth-1];
                else
                    st = ST_EMPTY;
            OP_DUP:
                if (model_depth == 0)
                    st = ST_EMPTY;
                else if (model_depth >= DEPTH)
                    st = ST_FULL;
                else
                begin
                    v = model_stack[model_depth-1];
                    model_stack[model_depth] = v;
                    model_depth++;
                end
            OP_SWAP:
                if (model_depth < 2)
                    st = ST_FEW;
                else
                begin
                    t = model_stack[model_depth-1];
                    model_stack[model_depth-1] = model_stack[model_depth-2];
                    model_stack[model_depth-2] = t;
                    v = model_stack[model_depth-1];
                end
            OP_CLEAR:
                model_depth = 0;
            OP_STORE:
                if (model_depth == 0)
                    st = ST_EMPTY;
                else
                begin
                    v = model_stack[model_depth-1];
                    if (vix < NUM_VARS)
                        var_bank[vix] = v;
                end
            default:
                if (vix < NUM_VARS)
                    v = var_bank[vix];
        endcase
        res.value  = v;
        res.status = st;
        res.depth  = model_depth[SDEPTH_W-1:0];
    endtask

    // start stays high when the next request follows at once
    task automatic issue_request(input func_t op, input word_t word,
                                 input logic [VIX_W-1:0] vix,
                                 input bit typed, input stack_result_t want);
        stack_result_t res;
        start      <= 1'b1;
        func       <= op;
        push_value <= word;
        var_index  <= vix;
        do
            @(posedge clk);
        while (busy);
        compute_stack_op(op, word, vix, res);
        if (typed)
            res = want;
        pending_results.push_back(res);
        if ($urandom_range(1, 100) <= idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic add_row(input func_t op, input word_t word, input logic [VIX_W-1:0] vix,
                           input bit typed, input word_t v, input status_t st,
                           input int d);
        directed_row_t r;
        r.op         = op;
        r.word       = word;
        r.vix        = vix;
        r.typed      = typed;
        r.want.value = v;
        r.want.status = st;
        r.want.depth = d[SDEPTH_W-1:0];
        directed_rows.push_back(r);
    endtask

    function automatic word_t rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '1;
        if (r == 1)
            return '0;
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [VIX_W-1:0] rand_vix();
        if ($urandom_range(0, 4) == 0)
            return VIX_W'($urandom_range(NUM_VARS, 31));
        return VIX_W'($urandom_range(0, NUM_VARS - 1));
    endfunction

    // growing mode favours push and dup, shrinking mode favours pop
    function automatic func_t pick_func(input bit growing);
        int r;
        r = $urandom_range(0, 99);
        if (growing)
        begin
            if (r < 45) return OP_PUSH;
            if (r < 55) return OP_DUP;
            if (r < 62) return OP_POP;
            if (r < 68) return OP_TOP;
            if (r < 78) return OP_SWAP;
            if (r < 86) return OP_STORE;
            if (r < 97) return OP_READ;
            return OP_CLEAR;
        end
        if (r < 15) return OP_PUSH;
        if (r < 20) return OP_DUP;
        if (r < 60) return OP_POP;
        if (r < 68) return OP_TOP;
        if (r < 78) return OP_SWAP;
        if (r < 86) return OP_STORE;
        if (r < 98) return OP_READ;
        return OP_CLEAR;
    endfunction

    always @(posedge clk)
    begin : result_check
        stack_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unrequested result", result_value, '0);
            else
            begin
                want = pending_results.pop_front();
                if (result_value !== want.value)
                    report_mismatch("result_value", result_value, want.value);
                if (status !== want.status)
                    report_mismatch("status", 64'(status), 64'(want.status));
                if (stack_depth !== want.depth)
                    report_mismatch("stack_depth", 64'(stack_depth), 64'(want.depth));
            end
        end
    end

    initial
    begin : stimulus
        int            idle_levels [3];
        stack_result_t no_care;
        func_t         op;

        idle_levels = '{0, 60, 29};
        no_care = '0;
        foreach (var_bank[i])
            var_bank[i] = '0;

        // empty-stack checks, then all ops, out-of-range indexes and clear
        add_row(OP_POP,   '0, 0,  1, '0, ST_EMPTY, 0);
        add_row(OP_TOP,   '0, 0,  1, '0, ST_EMPTY, 0);
        add_row(OP_DUP,   '0, 0,  1, '0, ST_EMPTY, 0);
        add_row(OP_SWAP,  '0, 0,  1, '0, ST_FEW,   0);
        add_row(OP_STORE, '0, 0,  1, '0, ST_EMPTY, 0);
        add_row(OP_READ,  '1, 0,  1, '0, ST_OK,    0);
        add_row(OP_READ,  '0, 31, 1, '0, ST_OK,    0);
        add_row(OP_PUSH,  '1, 31, 1, '0, ST_OK,    1);
        add_row(OP_SWAP,  '0, 0,  1, '0, ST_FEW,   1);
        add_row(OP_PUSH,  '0, 0,  1, '0, ST_OK,    2);
        add_row(OP_SWAP,  '0, 0,  1, '1, ST_OK,    2);
        add_row(OP_STORE, '0, 25, 1, '1, ST_OK,    2);
        add_row(OP_STORE, '0, 26, 1, '1, ST_OK,    2);
        add_row(OP_READ,  '0, 25, 1, '1, ST_OK,    2);
        add_row(OP_READ,  '0, 26, 1, '0, ST_OK,    2);
        add_row(OP_DUP,   '0, 0,  1, '1, ST_OK,    3);
        add_row(OP_POP,   '0, 0,  1, '1, ST_OK,    2);
        add_row(OP_POP,   '0, 0,  1, '1, ST_OK,    1);
        add_row(OP_TOP,   '1, 0,  1, '0, ST_OK,    1);
        add_row(OP_PUSH,  64'h5555_5555_5555_5555, 5, 0, '0, ST_OK, 0);
        add_row(OP_STORE, '0, 5,  0, '0, ST_OK,    0);
        add_row(OP_READ,  '0, 5,  0, '0, ST_OK,    0);
        add_row(OP_CLEAR, '1, 31, 1, '0, ST_OK,    0);
        add_row(OP_POP,   '0, 0,  1, '0, ST_EMPTY, 0);
        add_row(OP_READ,  '0, 25, 1, '1, ST_OK,    0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_request(directed_rows[i].op, directed_rows[i].word, directed_rows[i].vix,
                          directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = idle_levels[phase];
            if (phase == 1)
            begin
                // run the stack up to full, then hit it with pushes and dups
                while (model_depth < DEPTH)
                    issue_request(($urandom_range(0, 4) == 0) ? OP_DUP : OP_PUSH,
                                  rand_word(), rand_vix(), 0, no_care);
                repeat (6)
                    issue_request(($urandom_range(0, 1) == 0) ? OP_DUP : OP_PUSH,
                                  rand_word(), rand_vix(), 0, no_care);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                op = pick_func(((n / 40) % 2) == 0);
                issue_request(op, rand_word(), rand_vix(), 0, no_care);
            end
            // hold off until every outstanding request has answered
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
